/* design/rhh_pkg.sv */
// ----------------------------------------------------------------------------
// rhh_pkg: shared definitions for the Robin Hood hash table unit
// Operation and status codes, port widths and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package rhh_pkg;

   localparam int CAPACITY_DEF = 1024;

   localparam int FUNC_W    = 3;
   localparam int WORD_W    = 32;
   localparam int ORD_W     = 10;
   localparam int STATUS_W  = 2;
   localparam int ENTRIES_W = 11;

   // operation codes
   localparam logic [FUNC_W-1:0] FUNC_SET   = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_GET   = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_DEL   = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_KEYAT = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 3'd4;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FOUND    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

   // result data capture select
   localparam logic [2:0] RES_NONE = 3'd0;
   localparam logic [2:0] RES_ZERO = 3'd1;
   localparam logic [2:0] RES_ONES = 3'd2;
   localparam logic [2:0] RES_KEY  = 3'd3;
   localparam logic [2:0] RES_VAL  = 3'd4;

   typedef struct packed {
      logic                load;       // capture request, start at home slot
      logic                rd_idx;     // read slot at probe index
      logic                rd_next;    // read slot after probe index
      logic                wr_place;   // write carried entry at probe index
      logic                wr_update;  // write new value over matching slot
      logic                wr_shift;   // pull next slot back, advance index
      logic                wr_free;    // mark probe slot empty
      logic                wr_clr;     // sweep: mark sweep slot empty
      logic                swap;       // take resident entry as carry
      logic                advance;    // step probe index and distance
      logic                cnt_inc;
      logic                cnt_dec;
      logic                cnt_zero;
      logic                scan_step;  // ordinal scan: issue read and count
      logic [2:0]          res_sel;
      logic                rsp_load;
      logic [STATUS_W-1:0] rsp_status;
   } rhh_cmd_type;

   typedef struct packed {
      logic used;
      logic key_eq;
      logic dist_less;
      logic shift_stop;
      logic full;
      logic scan_hit;
      logic scan_done;
      logic clr_last;
      logic out_free;
   } rhh_sts_type;

endpackage

/* design/rhh_ram.sv */
// ----------------------------------------------------------------------------
// rhh_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rhh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/rhh_ctrl.sv */
// ----------------------------------------------------------------------------
// rhh_ctrl: operation sequencer
// Steps each operation through its probe, shift, scan or sweep and issues
// datapath commands.
// ----------------------------------------------------------------------------
module rhh_ctrl
   import rhh_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [FUNC_W-1:0] req_func,
   output logic              req_stall,
   output rhh_cmd_type       cmd,
   input  rhh_sts_type       sts
);

   localparam logic [3:0] S_INIT = 4'd0;
   localparam logic [3:0] S_IDLE = 4'd1;
   localparam logic [3:0] S_SRD  = 4'd2;
   localparam logic [3:0] S_SEV  = 4'd3;
   localparam logic [3:0] S_FRD  = 4'd4;
   localparam logic [3:0] S_FEV  = 4'd5;
   localparam logic [3:0] S_DRD  = 4'd6;
   localparam logic [3:0] S_DEV  = 4'd7;
   localparam logic [3:0] S_SCAN = 4'd8;
   localparam logic [3:0] S_CLR  = 4'd9;
   localparam logic [3:0] S_RESP = 4'd10;

   logic [3:0]          state_ff, state_in;
   logic [FUNC_W-1:0]   op_ff, op_in;
   logic [STATUS_W-1:0] status_ff, status_in;

   assign req_stall = (state_ff != S_IDLE);

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      status_in = status_ff;
      cmd       = '0;
      cmd.rsp_status = status_ff;
      case (state_ff)
         S_INIT: begin
            cmd.wr_clr = 1'b1;
            if (sts.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               op_in    = req_func;
               case (req_func)
                  FUNC_SET: begin
                     if (sts.full) begin
                        status_in   = ST_FULL;
                        cmd.res_sel = RES_ZERO;
                        state_in    = S_RESP;
                     end else begin
                        state_in = S_SRD;
                     end
                  end
                  FUNC_GET, FUNC_DEL: state_in = S_FRD;
                  FUNC_KEYAT:         state_in = S_SCAN;
                  FUNC_CLEAR:         state_in = S_CLR;
                  default: begin
                     status_in   = ST_DONE;
                     cmd.res_sel = RES_ZERO;
                     state_in    = S_RESP;
                  end
               endcase
            end
         end
         S_SRD: begin
            cmd.rd_idx = 1'b1;
            state_in   = S_SEV;
         end
         S_SEV: begin
            if (!sts.used) begin
               cmd.wr_place = 1'b1;
               cmd.cnt_inc  = 1'b1;
               cmd.res_sel  = RES_ZERO;
               status_in    = ST_DONE;
               state_in     = S_RESP;
            end else if (sts.key_eq) begin
               cmd.wr_update = 1'b1;
               cmd.res_sel   = RES_ZERO;
               status_in     = ST_FOUND;
               state_in      = S_RESP;
            end else begin
               // displace a richer resident and carry it on
               if (sts.dist_less) begin
                  cmd.wr_place = 1'b1;
                  cmd.swap     = 1'b1;
               end
               cmd.advance = 1'b1;
               state_in    = S_SRD;
            end
         end
         S_FRD: begin
            cmd.rd_idx = 1'b1;
            state_in   = S_FEV;
         end
         S_FEV: begin
            if (!sts.used) begin
               status_in   = ST_NOTFOUND;
               cmd.res_sel = (op_ff == FUNC_GET) ? RES_ONES : RES_ZERO;
               state_in    = S_RESP;
            end else if (sts.key_eq) begin
               if (op_ff == FUNC_GET) begin
                  status_in   = ST_FOUND;
                  cmd.res_sel = RES_VAL;
                  state_in    = S_RESP;
               end else begin
                  cmd.rd_next = 1'b1;
                  state_in    = S_DEV;
               end
            end else begin
               cmd.advance = 1'b1;
               state_in    = S_FRD;
            end
         end
         S_DRD: begin
            cmd.rd_next = 1'b1;
            state_in    = S_DEV;
         end
         S_DEV: begin
            if (sts.shift_stop) begin
               cmd.wr_free = 1'b1;
               cmd.cnt_dec = 1'b1;
               cmd.res_sel = RES_ZERO;
               status_in   = ST_FOUND;
               state_in    = S_RESP;
            end else begin
               cmd.wr_shift = 1'b1;
               state_in     = S_DRD;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_hit) begin
               cmd.res_sel = RES_KEY;
               status_in   = ST_FOUND;
               state_in    = S_RESP;
            end else if (sts.scan_done) begin
               cmd.res_sel = RES_ZERO;
               status_in   = ST_NOTFOUND;
               state_in    = S_RESP;
            end
         end
         S_CLR: begin
            cmd.wr_clr = 1'b1;
            if (sts.clr_last) begin
               cmd.cnt_zero = 1'b1;
               cmd.res_sel  = RES_ZERO;
               status_in    = ST_DONE;
               state_in     = S_RESP;
            end
         end
         S_RESP: begin
            if (sts.out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_INIT;
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
      op_ff     <= op_in;
      status_ff <= status_in;
   end

endmodule

/* design/rhh_dp.sv */
// ----------------------------------------------------------------------------
// rhh_dp: slot storage, probe registers and result register
// Holds the slot RAM, the carried entry, counters and the output stage.
// ----------------------------------------------------------------------------
module rhh_dp
   import rhh_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [WORD_W-1:0]    req_key,
   input  logic [WORD_W-1:0]    req_value,
   input  logic [ORD_W-1:0]     req_ordinal,
   input  rhh_cmd_type          cmd,
   output rhh_sts_type          sts,
   input  logic                 rsp_stall,
   output logic                 rsp_valid,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [WORD_W-1:0]    rsp_data,
   output logic [ENTRIES_W-1:0] rsp_entries
);

   localparam int IDX_W  = $clog2(CAPACITY);
   localparam int CNT_W  = IDX_W + 1;
   localparam int CMP_W  = (CNT_W > ORD_W) ? CNT_W : ORD_W;
   localparam int RAM_W  = 1 + IDX_W + 2 * WORD_W;
   localparam int FULL_LIMIT = (CAPACITY >> 2) + (CAPACITY >> 1);
   localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(FULL_LIMIT);

   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [IDX_W-1:0]    dist_ff, dist_in;
   logic [WORD_W-1:0]   key_ff, key_in;
   logic [WORD_W-1:0]   val_ff, val_in;
   logic [ORD_W-1:0]    ord_ff, ord_in;
   logic [CNT_W-1:0]    scan_ff, scan_in;
   logic                rd_vld_ff, rd_vld_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [WORD_W-1:0]   res_ff, res_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [WORD_W-1:0]   rsp_data_ff;
   logic [ENTRIES_W-1:0] rsp_entries_ff;

   logic                ram_wr_en, ram_rd_en;
   logic [IDX_W-1:0]    ram_wr_addr, ram_rd_addr;
   logic [RAM_W-1:0]    ram_wr_data, ram_rd_data;
   logic                rd_used;
   logic [IDX_W-1:0]    rd_dist;
   logic [WORD_W-1:0]   rd_key, rd_val;
   logic                scan_issue, scan_hit;

   // slot word fields
   assign rd_used = ram_rd_data[RAM_W-1];
   assign rd_dist = ram_rd_data[2*WORD_W +: IDX_W];
   assign rd_key  = ram_rd_data[WORD_W +: WORD_W];
   assign rd_val  = ram_rd_data[WORD_W-1:0];

   assign scan_issue = (scan_ff != CAP_CNT);
   assign scan_hit   = rd_vld_ff && rd_used && (CMP_W'(cnt_ff) == CMP_W'(ord_ff));

   // RAM port control
   always_comb begin
      ram_rd_en   = cmd.rd_idx || cmd.rd_next || (cmd.scan_step && scan_issue);
      ram_rd_addr = idx_ff;
      if (cmd.scan_step) begin
         ram_rd_addr = scan_ff[IDX_W-1:0];
      end else if (cmd.rd_next) begin
         ram_rd_addr = idx_ff + 1'b1;
      end
      ram_wr_en = cmd.wr_place || cmd.wr_update || cmd.wr_shift
                  || cmd.wr_free || cmd.wr_clr;
      ram_wr_addr = cmd.wr_clr ? scan_ff[IDX_W-1:0] : idx_ff;
      ram_wr_data = '0;
      if (cmd.wr_place) begin
         ram_wr_data = {1'b1, dist_ff, key_ff, val_ff};
      end else if (cmd.wr_update) begin
         ram_wr_data = {1'b1, rd_dist, rd_key, val_ff};
      end else if (cmd.wr_shift) begin
         ram_wr_data = {1'b1, rd_dist - 1'b1, rd_key, rd_val};
      end
   end

   rhh_ram #(
      .WIDTH (RAM_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // probe, scan and count next values
   always_comb begin
      idx_in   = idx_ff;
      dist_in  = dist_ff;
      key_in   = key_ff;
      val_in   = val_ff;
      ord_in   = ord_ff;
      scan_in  = scan_ff;
      cnt_in   = cnt_ff;
      count_in = count_ff;
      res_in   = res_ff;
      rd_vld_in = cmd.scan_step && scan_issue;
      if (cmd.load) begin
         idx_in  = req_key[IDX_W-1:0];
         dist_in = '0;
         key_in  = req_key;
         val_in  = req_value;
         ord_in  = req_ordinal;
         scan_in = '0;
         cnt_in  = '0;
      end
      if (cmd.advance || cmd.wr_shift) begin
         idx_in = idx_ff + 1'b1;
      end
      if (cmd.advance) begin
         dist_in = cmd.swap ? rd_dist + 1'b1 : dist_ff + 1'b1;
      end
      if (cmd.swap) begin
         key_in = rd_key;
         val_in = rd_val;
      end
      if (cmd.wr_clr || (cmd.scan_step && scan_issue)) begin
         scan_in = scan_ff + 1'b1;
      end
      if (cmd.scan_step && rd_vld_ff && rd_used && !scan_hit) begin
         cnt_in = cnt_ff + 1'b1;
      end
      if (cmd.cnt_zero) begin
         count_in = '0;
      end else if (cmd.cnt_inc) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.cnt_dec && (count_ff != '0)) begin
         count_in = count_ff - 1'b1;
      end
      case (cmd.res_sel)
         RES_ZERO: res_in = '0;
         RES_ONES: res_in = '1;
         RES_KEY:  res_in = rd_key;
         RES_VAL:  res_in = rd_val;
         default:  res_in = res_ff;
      endcase
   end

   // hold result until the transfer completes
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         scan_ff      <= scan_in;
         rd_vld_ff    <= rd_vld_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff  <= idx_in;
      dist_ff <= dist_in;
      key_ff  <= key_in;
      val_ff  <= val_in;
      ord_ff  <= ord_in;
      cnt_ff  <= cnt_in;
      res_ff  <= res_in;
      if (cmd.rsp_load) begin
         rsp_status_ff  <= cmd.rsp_status;
         rsp_data_ff    <= res_ff;
         rsp_entries_ff <= ENTRIES_W'(count_ff);
      end
   end

   // status to controller
   always_comb begin
      sts.used       = rd_used;
      sts.key_eq     = (rd_key == key_ff);
      sts.dist_less  = (rd_dist < dist_ff);
      sts.shift_stop = !rd_used || (rd_dist == '0);
      sts.full       = (count_ff > FULL_CNT);
      sts.scan_hit   = scan_hit;
      sts.scan_done  = !scan_issue && !rd_vld_ff;
      sts.clr_last   = (scan_ff[IDX_W-1:0] == {IDX_W{1'b1}});
      sts.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_data    = rsp_data_ff;
   assign rsp_entries = rsp_entries_ff;

   // never overwrite a result that is still waiting
   assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result loaded over a pending transfer");

   // the entry count moves by at most one, except on clear
   assert property (@(posedge clock) disable iff (reset)
      !cmd.cnt_zero |=> (count_ff == $past(count_ff))
         || (count_ff == $past(count_ff) + 1'b1)
         || (count_ff == $past(count_ff) - 1'b1))
      else $error("entry count jumped");

   // a new result appears only after a load command
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.rsp_load))
      else $error("result valid without load");

   // the count never exceeds the capacity
   assert property (@(posedge clock) disable iff (reset)
      cmd.cnt_inc |-> (count_ff < CAP_CNT))
      else $error("insert into a full table");

endmodule

/* design/robin_hood_hash_table_unit.sv */
// ----------------------------------------------------------------------------
// robin_hood_hash_table_unit: Robin Hood hash table with backward-shift delete
//
//   channel | direction | ports
//   --------+-----------+---------------------------------------------------
//   req     | in        | req_valid, req_stall, req_func, req_key,
//           |           | req_value, req_ordinal
//   rsp     | out       | rsp_valid, rsp_stall, rsp_status, rsp_data,
//           |           | rsp_entries
//
// Set, get: the request is taken, then each probed slot is read from the RAM
// and evaluated in turn, and the result is loaded. Delete adds a read and
// check of the slot after the match and a read and shift back per entry
// moved. Key-at reads the slots in order (one slot read per cycle); clear
// empties every slot in order (one slot cleared per cycle). The slot RAM has
// one read and one write port, one slot access each per cycle.
// After reset a clearing pass over every slot runs before the first
// request is taken. A result still waiting in the output register holds the
// finished operation in its load step, and the request side stays stalled
// until that result has moved on.
// ----------------------------------------------------------------------------
module robin_hood_hash_table_unit
   import rhh_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [FUNC_W-1:0]    req_func,
   input  logic [WORD_W-1:0]    req_key,
   input  logic [WORD_W-1:0]    req_value,
   input  logic [ORD_W-1:0]     req_ordinal,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [WORD_W-1:0]    rsp_data,
   output logic [ENTRIES_W-1:0] rsp_entries
);

   rhh_cmd_type cmd;
   rhh_sts_type sts;

   // sequencer
   rhh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_stall (req_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   // storage and result path
   rhh_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_key     (req_key),
      .req_value   (req_value),
      .req_ordinal (req_ordinal),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_status  (rsp_status),
      .rsp_data    (rsp_data),
      .rsp_entries (rsp_entries)
   );

endmodule
